FILE: rtl/core/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Types, widths and constants shared by the interval statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package isa_pkg;

  localparam int COUNT_WIDTH   = 32;
  localparam int SUM_SEC_WIDTH = 48;

  localparam int SEC_W     = 32;
  localparam int USEC_W    = 20;
  localparam int TOTAL_W   = 32;
  localparam int SUM_OUT_W = 48;

  // dividend of the fraction pass: remainder * 1e6 + usec
  localparam int FRAC_W = COUNT_WIDTH + USEC_W;
  localparam int STEP_W = $clog2(SUM_SEC_WIDTH);

  localparam logic [USEC_W-1:0] USEC_MAX     = USEC_W'(999999);
  localparam logic [USEC_W:0]   USEC_PER_SEC = (USEC_W + 1)'(1000000);

  typedef struct packed {
    logic [SEC_W-1:0]  sample_sec;
    logic [USEC_W-1:0] sample_usec;
  } sample_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]   sample_total;
    logic [SEC_W-1:0]     min_sec;
    logic [USEC_W-1:0]    min_usec;
    logic [SEC_W-1:0]     max_sec;
    logic [USEC_W-1:0]    max_usec;
    logic [SUM_OUT_W-1:0] sum_sec;
    logic [USEC_W-1:0]    sum_usec;
    logic [SUM_OUT_W-1:0] mean_sec;
    logic [USEC_W-1:0]    mean_usec;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_INT,
    ST_MUL,
    ST_DIV_FRAC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_int;
    logic load_frac;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/isa_sample_if.sv
// ----------------------------------------------------------------------------
// isa_sample_if
// Valid/ready channel carrying one interval sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface isa_sample_if;
  import isa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/isa_result_if.sv
// ----------------------------------------------------------------------------
// isa_result_if
// Valid/ready channel carrying one statistics result.
// ----------------------------------------------------------------------------
`default_nettype none

interface isa_result_if;
  import isa_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/isa_divider.sv
// ----------------------------------------------------------------------------
// isa_divider
// Restoring radix-2 divider, one quotient bit per step. Serves both the
// whole-seconds pass and the microsecond fraction pass of the mean.
// ----------------------------------------------------------------------------
`default_nettype none

module isa_divider (
  input  wire                             clk,
  input  isa_pkg::div_ctl_t               ctl,
  input  wire [isa_pkg::COUNT_WIDTH-1:0]   divisor,
  input  wire [isa_pkg::SUM_SEC_WIDTH-1:0] int_dividend,
  input  wire [isa_pkg::FRAC_W-1:0]        frac_dividend,
  output logic [isa_pkg::COUNT_WIDTH-1:0]  rem,
  output logic [isa_pkg::SUM_SEC_WIDTH-1:0] quo
);
  import isa_pkg::*;

  logic [SUM_SEC_WIDTH-1:0] shreg;
  logic [COUNT_WIDTH:0]     trial;
  logic [COUNT_WIDTH:0]     diff;
  logic                     fits;

  assign trial = {rem, shreg[SUM_SEC_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctl.load_int) begin
      rem   <= '0;
      shreg <= int_dividend;
      quo   <= '0;
    end else if (ctl.load_frac) begin
      // upper part is already below the divisor, so only USEC_W bits remain
      rem   <= frac_dividend[FRAC_W-1:USEC_W];
      shreg <= {frac_dividend[USEC_W-1:0], {(SUM_SEC_WIDTH - USEC_W){1'b0}}};
      quo   <= '0;
    end else if (ctl.step) begin
      rem   <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      shreg <= {shreg[SUM_SEC_WIDTH-2:0], 1'b0};
      quo   <= {quo[SUM_SEC_WIDTH-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/interval_stats_accumulator.sv
// ----------------------------------------------------------------------------
// interval_stats_accumulator
// Running count, minimum, maximum, total and mean of time intervals.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one item = seconds plus microseconds of an interval.
//             Microseconds above 999999 are clamped to 999999.
//   results : source channel, one item per sample with the count, min, max,
//             normalized total and mean after that sample.
// Sequence:
//   A sample is taken only while the sequencer is idle. It then passes
//   through the update of the statistics, the whole seconds of the mean in
//   the shared divider, forming remainder * 1e6 + usec, the microseconds in
//   the same divider and the loading of the output register, in that order.
//   No new sample is taken until the sequencer is idle again, since the
//   single restoring divider serves one sample at a time.
// Reset: rst clears count, min, max and total to zero and drops any result.
// Stall: the result sits in an output register while the next sample is
//   processed; a finished item waits in the last step until that register is
//   free, and no new sample is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_stats_accumulator (
  input  wire          clk,
  input  wire          rst,
  isa_sample_if.sink   samples,
  isa_result_if.source results
);
  import isa_pkg::*;

  state_t state;
  state_t state_next;
  div_ctl_t div_ctl;

  logic [STEP_W-1:0] cnt;

  logic [SEC_W-1:0]  s_sec;
  logic [USEC_W-1:0] s_usec;

  logic [COUNT_WIDTH-1:0]   count;
  logic [COUNT_WIDTH-1:0]   count_next;
  logic [SEC_W-1:0]         least_sec;
  logic [USEC_W-1:0]        least_usec;
  logic [SEC_W-1:0]         most_sec;
  logic [USEC_W-1:0]        most_usec;
  logic [SUM_SEC_WIDTH-1:0] acc_sec;
  logic [SUM_SEC_WIDTH-1:0] acc_sec_next;
  logic [USEC_W-1:0]        acc_usec;
  logic [USEC_W-1:0]        acc_usec_next;

  logic [USEC_W:0]          usec_sum;
  logic                     usec_carry;
  logic [USEC_W:0]          usec_norm;
  logic [SUM_SEC_WIDTH:0]   sec_sum;
  logic                     first;
  logic                     take_max;
  logic                     take_min;

  logic [SUM_SEC_WIDTH-1:0] mean_sec;
  logic [COUNT_WIDTH-1:0]   div_rem;
  logic [SUM_SEC_WIDTH-1:0] div_quo;
  logic [FRAC_W-1:0]        frac_dividend;

  logic    out_valid;
  result_t out_data;
  logic    out_free;

  // ---------------------------------------------------------------- update
  always_comb begin
    usec_sum   = {1'b0, acc_usec} + {1'b0, s_usec};
    usec_carry = usec_sum >= USEC_PER_SEC;
    usec_norm  = usec_carry ? usec_sum - USEC_PER_SEC : usec_sum;
    sec_sum    = {1'b0, acc_sec} + (SUM_SEC_WIDTH + 1)'(s_sec)
               + (SUM_SEC_WIDTH + 1)'(usec_carry);
    // saturate the total when seconds overflow
    if (sec_sum[SUM_SEC_WIDTH]) begin
      acc_sec_next  = '1;
      acc_usec_next = USEC_MAX;
    end else begin
      acc_sec_next  = sec_sum[SUM_SEC_WIDTH-1:0];
      acc_usec_next = usec_norm[USEC_W-1:0];
    end
    count_next = (count == '1) ? count : count + COUNT_WIDTH'(1);
    first      = count == '0;
    take_max   = s_sec > most_sec || (s_sec == most_sec && s_usec > most_usec);
    take_min   = s_sec < least_sec || (s_sec == least_sec && s_usec < least_usec);
  end

  assign frac_dividend = FRAC_W'(div_rem) * FRAC_W'(USEC_PER_SEC) + FRAC_W'(acc_usec);

  isa_divider u_div (
    .clk           (clk),
    .ctl           (div_ctl),
    .divisor       (count),
    .int_dividend  (acc_sec_next),
    .frac_dividend (frac_dividend),
    .rem           (div_rem),
    .quo           (div_quo)
  );

  // ------------------------------------------------------------- sequencer
  assign out_free      = !out_valid || results.ready;
  assign samples.ready = state == ST_IDLE && !rst;

  always_comb begin
    state_next = state;
    div_ctl    = '0;
    case (state)
      ST_IDLE: begin
        if (samples.valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        div_ctl.load_int = 1'b1;
        state_next       = ST_DIV_INT;
      end
      ST_DIV_INT: begin
        div_ctl.step = 1'b1;
        if (cnt == '0) state_next = ST_MUL;
      end
      ST_MUL: begin
        div_ctl.load_frac = 1'b1;
        state_next        = ST_DIV_FRAC;
      end
      ST_DIV_FRAC: begin
        div_ctl.step = 1'b1;
        if (cnt == '0) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // -------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      least_sec  <= '0;
      least_usec <= '0;
      most_sec   <= '0;
      most_usec  <= '0;
      acc_sec    <= '0;
      acc_usec   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_UPDATE) begin
        count    <= count_next;
        acc_sec  <= acc_sec_next;
        acc_usec <= acc_usec_next;
        if (first || take_max) begin
          most_sec  <= s_sec;
          most_usec <= s_usec;
        end
        if (first || take_min) begin
          least_sec  <= s_sec;
          least_usec <= s_usec;
        end
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s_sec  <= samples.data.sample_sec;
      s_usec <= (samples.data.sample_usec > USEC_MAX) ? USEC_MAX
                                                      : samples.data.sample_usec;
    end
    case (state)
      ST_UPDATE: cnt <= STEP_W'(SUM_SEC_WIDTH - 1);
      ST_MUL:    cnt <= STEP_W'(USEC_W - 1);
      default:   cnt <= cnt - STEP_W'(1);
    endcase
    // whole seconds of the mean are final when the fraction pass loads
    if (state == ST_MUL) mean_sec <= div_quo;
    if (state == ST_OUT && out_free) begin
      out_data.sample_total <= TOTAL_W'(count);
      out_data.min_sec      <= least_sec;
      out_data.min_usec     <= least_usec;
      out_data.max_sec      <= most_sec;
      out_data.max_usec     <= most_usec;
      out_data.sum_sec      <= SUM_OUT_W'(acc_sec);
      out_data.sum_usec     <= acc_usec;
      out_data.mean_sec     <= SUM_OUT_W'(mean_sec);
      out_data.mean_usec    <= div_quo[USEC_W-1:0];
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // ------------------------------------------------------------ assertions
  a_accept_starts_update: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> state == ST_UPDATE)
    else $error("accepted item did not start an update");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count >= $past(count))
    else $error("sample count went down");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> (least_sec < most_sec ||
                     (least_sec == most_sec && least_usec <= most_usec)))
    else $error("minimum above maximum");

  a_total_usec_normalized: assert property (@(posedge clk) disable iff (rst)
    {1'b0, acc_usec} < USEC_PER_SEC)
    else $error("total microseconds not normalized");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_free |=> results.valid && state == ST_IDLE)
    else $error("finished item not presented");

  a_mean_usec_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> {1'b0, results.data.mean_usec} < USEC_PER_SEC)
    else $error("mean microseconds out of range");

endmodule

`default_nettype wire
